// File: rtl/seven_segment_mux_blink_animate_assert.svh
// Assertion macros used by the display driver checker.
`ifndef SEVEN_SEGMENT_MUX_BLINK_ANIMATE_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_BLINK_ANIMATE_ASSERT_SVH

// Clocked assertion, ignored while reset is asserted.
`define SSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SSM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ssm_pkg.sv
// Types, codes and font tables of the multiplexed seven-segment driver.
package ssm_pkg;

    localparam int DIGITS_DEF = 4;
    localparam int BLINK_UNIT = 100;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [1:0] {
        OP_SCAN     = 2'd0,
        OP_TICK     = 2'd1,
        OP_LOAD_RAW = 2'd2,
        OP_LOAD_HEX = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLINK_MASK   = 3'd0,
        REG_BLINK_PERIOD = 3'd1,
        REG_STEP_TICKS   = 3'd2,
        REG_ACTIVE_LOW   = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] value;
        logic [3:0]  digit_mask;
        logic        animate;
    } in_word_t;

    typedef struct packed {
        logic [7:0] segment_drive;
        logic [3:0] common_drive;
        logic       animating;
    } result_t;

    // Per-lane control, fanned out from the sequencer to every digit lane.
    typedef struct packed {
        logic       step_en;
        logic [2:0] step_idx;
        logic       load_en;
        logic       load_anim;
        logic       load_hex;
    } lane_ctl_t;

    localparam logic [7:0] SEG_A = 8'h01;
    localparam logic [7:0] SEG_B = 8'h02;
    localparam logic [7:0] SEG_C = 8'h04;
    localparam logic [7:0] SEG_D = 8'h08;
    localparam logic [7:0] SEG_E = 8'h10;
    localparam logic [7:0] SEG_F = 8'h20;
    localparam logic [7:0] SEG_G = 8'h40;

    function automatic logic [7:0] hex_font(input logic [3:0] nib);
        logic [7:0] p;
        case (nib)
            4'h0: p = 8'h3F;
            4'h1: p = 8'h06;
            4'h2: p = 8'h5B;
            4'h3: p = 8'h4F;
            4'h4: p = 8'h66;
            4'h5: p = 8'h6D;
            4'h6: p = 8'h7D;
            4'h7: p = 8'h07;
            4'h8: p = 8'h7F;
            4'h9: p = 8'h6F;
            4'hA: p = 8'h77;
            4'hB: p = 8'h7C;
            4'hC: p = 8'h39;
            4'hD: p = 8'h5E;
            4'hE: p = 8'h79;
            4'hF: p = 8'h71;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // Segment lit by each chase step; step 7 lights none.
    function automatic logic [7:0] chase_set(input logic [2:0] s);
        logic [7:0] m;
        case (s)
            3'd0: m = SEG_F;
            3'd1: m = SEG_A;
            3'd2: m = SEG_B;
            3'd3: m = SEG_C;
            3'd4: m = SEG_D;
            3'd5: m = SEG_E;
            3'd6: m = SEG_G;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Segment released by each chase step; step 0 releases none.
    function automatic logic [7:0] chase_clr(input logic [2:0] s);
        logic [7:0] m;
        case (s)
            3'd1: m = SEG_F;
            3'd2: m = SEG_A;
            3'd3: m = SEG_B;
            3'd4: m = SEG_C;
            3'd5: m = SEG_D;
            3'd6: m = SEG_E;
            3'd7: m = SEG_G;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/ssm_lane.sv
// One digit lane: shown and target patterns, load decode and chase step.
module ssm_lane import ssm_pkg::*; #(
    parameter int DIGITS = DIGITS_DEF,
    parameter int LANE   = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lane_ctl_t   ctl,
    input  logic [31:0] value,
    input  logic [3:0]  digit_mask,
    output logic [7:0]  shown
);

    localparam int BYTE_IDX = DIGITS - 1 - LANE;

    logic [7:0] shown_reg, shown_next;
    logic [7:0] target_reg, target_next;
    logic [7:0] raw_pat;
    logic [7:0] hex_pat;
    logic [7:0] load_pat;
    logic [7:0] blanked;
    logic [7:0] stepped;
    logic [7:0] set_m;
    logic [7:0] clr_m;

    // Raw byte for this digit; digits beyond the word read as blank.
    if (BYTE_IDX < 4) begin : g_raw
        assign raw_pat = value[8*BYTE_IDX +: 8];
    end else begin : g_raw_none
        assign raw_pat = 8'h00;
    end

    // Hex nibble: the count of set mask bits below this digit picks it.
    if (LANE < 4) begin : g_hex
        logic [1:0] nib_idx;
        always_comb begin
            nib_idx = 2'd0;
            for (int j = 0; j < LANE; j++) begin
                nib_idx = nib_idx + 2'(digit_mask[j]);
            end
        end
        assign hex_pat = digit_mask[LANE] ? hex_font(value[4*nib_idx +: 4]) : 8'h00;
    end else begin : g_hex_none
        assign hex_pat = 8'h00;
    end

    assign load_pat = ctl.load_hex ? hex_pat : raw_pat;
    assign set_m    = chase_set(ctl.step_idx);
    assign clr_m    = chase_clr(ctl.step_idx);

    always_comb begin
        blanked = shown_reg;
        if (ctl.step_idx == 3'd0 && shown_reg != target_reg) begin
            blanked = 8'h00;
        end
        stepped = blanked;
        if (blanked != target_reg) begin
            stepped = blanked | set_m;
            if ((target_reg & clr_m) == 8'h00) begin
                stepped = stepped & ~clr_m;
            end
        end
    end

    always_comb begin
        shown_next  = shown_reg;
        target_next = target_reg;
        if (ctl.step_en) begin
            shown_next = stepped;
        end else if (ctl.load_en) begin
            if (ctl.load_anim) begin
                target_next = load_pat;
            end else begin
                shown_next = load_pat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg  <= 8'h00;
            target_reg <= 8'h00;
        end else begin
            shown_reg  <= shown_next;
            target_reg <= target_next;
        end
    end

    assign shown = shown_reg;

endmodule

// File: rtl/ssm_skid.sv
// Two-entry result buffer: output register plus skid register.
module ssm_skid import ssm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    out_valid_reg;
    result_t out_word_reg;
    logic    skid_valid_reg;
    result_t skid_word_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : in_word;
        end else if (in_valid && in_ready) begin
            skid_word_reg <= in_word;
        end
    end

endmodule

// File: rtl/seven_segment_mux_blink_animate.sv
// Top level of the multiplexed seven-segment driver with blink and chase.
//
//  channel  direction  handshake           word
//  s_       in         s_valid / s_ready   in_word_t  (operation, value, mask, animate)
//  m_       out        m_valid / m_ready   result_t   (segment, common, animating)
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word per cycle while s_ready is high: each accepted word updates the
// sequencer and lane state at its accept edge, and its result is registered at
// that same edge, into the output register (offered on m_) or, if m_ stalls, the skid register.
// Each digit lane applies loads and chase steps to its own digit in parallel;
// the scan mux merges the lanes into the drive register.
// A stalled m_ side is absorbed by a one-word skid register; s_ready drops only
// when both output registers are full. cfg_ready is always high.
// Reset (aresetn low, synchronous) clears all patterns, counters and buffers.
module seven_segment_mux_blink_animate import ssm_pkg::*; #(
    parameter int DIGITS = DIGITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(DIGITS);

    // Configuration registers
    logic [3:0]  blink_mask_reg;
    logic [7:0]  blink_period_reg;
    logic [9:0]  step_ticks_reg;
    logic        active_low_reg;

    // Sequencer state
    logic [IDX_W-1:0] scan_index_reg, scan_index_next;
    logic [2:0]       chase_step_reg, chase_step_next;
    logic             chase_busy_reg, chase_busy_next;
    logic             chase_running_reg, chase_running_next;
    logic [9:0]       chase_cd_reg, chase_cd_next;
    logic             blink_phase_reg, blink_phase_next;
    logic [14:0]      blink_cd_reg, blink_cd_next;
    logic [7:0]       seg_reg, seg_next;
    logic [3:0]       com_reg, com_next;

    logic       s_fire;
    logic       cfg_fire;
    logic       is_scan;
    logic       is_tick;
    logic       is_load;
    logic [9:0] chase_cd_dec;
    logic       step_en;
    lane_ctl_t  ctl;
    logic [7:0] shown_lane [DIGITS];
    logic [3:0] idx_ext;
    logic       blink_skip;
    logic [3:0] new_mask_v;
    logic [7:0] new_period_v;
    result_t    result_word;
    logic       skid_ready;

    assign s_ready   = skid_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign is_scan = s_fire && s_data.operation == OP_SCAN;
    assign is_tick = s_fire && s_data.operation == OP_TICK;
    // Drop loads while the chase is drawing.
    assign is_load = s_fire && !chase_busy_reg &&
                     (s_data.operation == OP_LOAD_RAW || s_data.operation == OP_LOAD_HEX);

    assign chase_cd_dec = (chase_cd_reg != 10'd0) ? chase_cd_reg - 10'd1 : 10'd0;
    assign step_en      = is_tick && chase_running_reg && chase_cd_dec == 10'd0;

    assign ctl.step_en   = step_en;
    assign ctl.step_idx  = chase_step_reg;
    assign ctl.load_en   = is_load;
    assign ctl.load_anim = s_data.animate;
    assign ctl.load_hex  = s_data.operation == OP_LOAD_HEX;

    // Digit lanes
    for (genvar g = 0; g < DIGITS; g++) begin : g_lane
        ssm_lane #(
            .DIGITS (DIGITS),
            .LANE   (g)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .value      (s_data.value),
            .digit_mask (s_data.digit_mask),
            .shown      (shown_lane[g])
        );
    end

    // Chase sequencer: count down on ticks, step when the count runs out, restart on an animated load.
    always_comb begin
        chase_step_next    = chase_step_reg;
        chase_busy_next    = chase_busy_reg;
        chase_running_next = chase_running_reg;
        chase_cd_next      = chase_cd_reg;
        if (is_tick) begin
            chase_cd_next = chase_cd_dec;
            if (step_en) begin
                chase_cd_next = step_ticks_reg;
                if (chase_step_reg == 3'd7) begin
                    chase_step_next    = 3'd0;
                    chase_busy_next    = 1'b0;
                    chase_running_next = 1'b0;
                end else begin
                    chase_step_next = chase_step_reg + 3'd1;
                    if (chase_step_reg == 3'd0) begin
                        chase_busy_next = 1'b1;
                    end
                end
            end
        end else if (is_load && s_data.animate) begin
            // Restart the chase; the first step runs on the next tick.
            chase_running_next = 1'b1;
            chase_cd_next      = 10'd0;
        end
    end

    assign new_mask_v   = cfg_data[3:0];
    assign new_period_v = cfg_data[7:0];

    // Blink timing: ticks count down; a scan that finds the count at zero toggles the phase and reloads it.
    always_comb begin
        blink_phase_next = blink_phase_reg;
        blink_cd_next    = blink_cd_reg;
        if (is_scan && blink_cd_reg == 15'd0) begin
            blink_phase_next = !blink_phase_reg;
            blink_cd_next    = 15'(blink_period_reg) * 15'(BLINK_UNIT);
        end else if (is_tick && blink_cd_reg != 15'd0) begin
            blink_cd_next = blink_cd_reg - 15'd1;
        end
        // A changed blink setting restarts the phase dark.
        if (cfg_fire) begin
            case (cfg_index)
                REG_BLINK_MASK: begin
                    if (new_mask_v != blink_mask_reg) begin
                        blink_phase_next = 1'b1;
                        blink_cd_next    = 15'(blink_period_reg) * 15'(BLINK_UNIT);
                    end
                end
                REG_BLINK_PERIOD: begin
                    if (new_period_v != blink_period_reg) begin
                        blink_phase_next = 1'b1;
                        blink_cd_next    = 15'(new_period_v) * 15'(BLINK_UNIT);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Scan mux: merge the lanes into the drive register.
    assign idx_ext    = 4'(scan_index_reg);
    assign blink_skip = idx_ext < 4'd4 && blink_mask_reg[idx_ext[1:0]] && blink_phase_next;

    always_comb begin
        seg_next        = seg_reg;
        com_next        = com_reg;
        scan_index_next = scan_index_reg;
        if (is_scan) begin
            com_next = 4'd0;
            if (!blink_skip) begin
                seg_next = shown_lane[scan_index_reg];
                if (idx_ext < 4'd4) begin
                    com_next = 4'b0001 << idx_ext[1:0];
                end
            end
            if (scan_index_reg == IDX_W'(DIGITS - 1)) begin
                scan_index_next = '0;
            end else begin
                scan_index_next = scan_index_reg + IDX_W'(1);
            end
        end
    end

    // Result: port levels after this word, inverted for common anode.
    assign result_word.segment_drive = seg_next ^ {8{active_low_reg}};
    assign result_word.common_drive  = com_next ^ {4{active_low_reg}};
    assign result_word.animating     = chase_busy_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_mask_reg    <= 4'd0;
            blink_period_reg  <= 8'd0;
            step_ticks_reg    <= 10'd50;
            active_low_reg    <= 1'b0;
            scan_index_reg    <= '0;
            chase_step_reg    <= 3'd0;
            chase_busy_reg    <= 1'b0;
            chase_running_reg <= 1'b0;
            chase_cd_reg      <= 10'd0;
            blink_phase_reg   <= 1'b0;
            blink_cd_reg      <= 15'd0;
            seg_reg           <= 8'd0;
            com_reg           <= 4'd0;
        end else begin
            scan_index_reg    <= scan_index_next;
            chase_step_reg    <= chase_step_next;
            chase_busy_reg    <= chase_busy_next;
            chase_running_reg <= chase_running_next;
            chase_cd_reg      <= chase_cd_next;
            blink_phase_reg   <= blink_phase_next;
            blink_cd_reg      <= blink_cd_next;
            seg_reg           <= seg_next;
            com_reg           <= com_next;
            if (cfg_fire) begin
                case (cfg_index)
                    REG_BLINK_MASK:   blink_mask_reg   <= new_mask_v;
                    REG_BLINK_PERIOD: blink_period_reg <= new_period_v;
                    REG_STEP_TICKS:   step_ticks_reg   <= cfg_data[9:0];
                    REG_ACTIVE_LOW:   active_low_reg   <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register with skid
    ssm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_fire),
        .in_ready  (skid_ready),
        .in_word   (result_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_data)
    );

endmodule

// File: rtl/ssm_checker.sv
// Port-level checker for the seven-segment driver, bound to the top level.
`include "seven_segment_mux_blink_animate_assert.svh"

module ssm_checker import ssm_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    `SSM_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `SSM_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")
    `SSM_ASSERT(a_backpressure, aclk, aresetn, !s_ready |-> m_valid, "input stalled with output empty")
    `SSM_ASSERT(a_common_onehot, aclk, aresetn, m_valid |-> ($onehot0(m_data.common_drive) || $onehot0(~m_data.common_drive)), "more than one common line on")

    // Unused by the checks above but kept visible on waveforms.
    logic in_fire_seen;
    assign in_fire_seen = s_valid && s_ready;

    `SSM_ASSERT(a_accept_fills, aclk, aresetn, in_fire_seen |=> m_valid, "accepted word gave no result")

endmodule

bind seven_segment_mux_blink_animate ssm_checker u_ssm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
